>>> rtl/fbfl_pkg.sv
package fbfl_pkg;

  // command codes
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_REINIT = 2'd2;

  // status codes
  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FREED     = 3'd2;
  localparam logic [2:0] ST_IGNORED   = 3'd3;
  localparam logic [2:0] ST_REINIT    = 3'd4;

  // request payload
  typedef struct packed {
    logic [1:0] command;
    logic [1:0] block_index;
    logic       block_present;
  } req_t;

  // response payload
  typedef struct packed {
    logic [2:0] status;
    logic [1:0] granted_index;
    logic [5:0] granted_offset;
  } rsp_t;

endpackage

>>> rtl/fbfl_ram.sv
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fixed_block_free_list_allocator_top.sv
// allocate: busy while the head entry's link is read, then the response (empty pool: no busy)
// free, null free, unused command: respond in the next cycle, next start accepted at once
// reinitialize: one link memory write per cycle, response after the last entry is written
// reset starts the same rebuild pass (busy high, no response)
// a response is shown on done for one cycle; the receiver cannot stall it
module fixed_block_free_list_allocator_top
  import fbfl_pkg::*;
#(
  parameter int NUM_BLOCKS  = 4,
  parameter int BLOCK_BYTES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LINK_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BLOCKS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0]       state;
  logic [IDX_W-1:0] head;
  logic             empty;
  logic [IDX_W-1:0] sweep_cnt;
  logic             sweep_report;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [LINK_W-1:0] wdata;
  logic [LINK_W-1:0] rdata;
  logic              accept;
  logic              free_ok;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign free_ok = req.block_present && (32'(req.block_index) < NUM_BLOCKS);

  // link memory: {end mark, next index}, always reading the head entry
  fbfl_ram #(
    .WIDTH(LINK_W),
    .DEPTH(NUM_BLOCKS)
  ) u_links (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(head),
    .rdata(rdata)
  );

  // write port: rebuild sweep or push on free
  always_comb begin
    we    = 1'b0;
    waddr = sweep_cnt;
    wdata = {(sweep_cnt == LAST), ((sweep_cnt == LAST) ? '0 : sweep_cnt + IDX_W'(1))};
    if (state == S_SWEEP) begin
      we = 1'b1;
    end else if (accept && (req.command == CMD_FREE) && free_ok) begin
      we    = 1'b1;
      waddr = IDX_W'(req.block_index);
      wdata = {empty, head};
    end
  end

  // control and response
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      head         <= '0;
      empty        <= 1'b0;
      sweep_cnt    <= '0;
      sweep_report <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rsp.granted_index  <= '0;
            rsp.granted_offset <= '0;
            unique case (req.command)
              CMD_ALLOC: begin
                if (empty) begin
                  rsp.status <= ST_EMPTY;
                  done       <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              CMD_FREE: begin
                done <= 1'b1;
                if (free_ok) begin
                  head       <= IDX_W'(req.block_index);
                  empty      <= 1'b0;
                  rsp.status <= ST_FREED;
                end else begin
                  rsp.status <= ST_IGNORED;
                end
              end
              CMD_REINIT: begin
                state        <= S_SWEEP;
                sweep_cnt    <= '0;
                sweep_report <= 1'b1;
              end
              default: begin
                rsp.status <= ST_IGNORED;
                done       <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          // pop: link of the head entry is now on rdata
          done               <= 1'b1;
          rsp.status         <= ST_ALLOCATED;
          rsp.granted_index  <= 2'(head);
          rsp.granted_offset <= 6'(6'(head) * 6'(BLOCK_BYTES));
          if (rdata[LINK_W-1]) begin
            empty <= 1'b1;
          end else begin
            head <= rdata[IDX_W-1:0];
          end
          state <= S_IDLE;
        end
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + IDX_W'(1);
          if (sweep_cnt == LAST) begin
            state        <= S_IDLE;
            head         <= '0;
            empty        <= 1'b0;
            sweep_report <= 1'b0;
            if (sweep_report) begin
              done               <= 1'b1;
              rsp.status         <= ST_REINIT;
              rsp.granted_index  <= '0;
              rsp.granted_offset <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/fbfl_checker.sv
module fbfl_checker
  import fbfl_pkg::*;
#(
  parameter int NUM_BLOCKS = 4
) (
  input logic clk,
  input logic rst,
  input logic start,
  input req_t req,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  // reset starts the rebuild pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // a real free of an in-range block answers on the next cycle
  a_free_resp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.command == CMD_FREE && req.block_present &&
     32'(req.block_index) < NUM_BLOCKS) |=> (done && rsp.status == ST_FREED))
    else $error("free transfer without freed response");

  // reinitialize holds off new commands
  a_reinit_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.command == CMD_REINIT) |=> (busy && !done))
    else $error("reinitialize did not start its pass");

  // only a grant carries an index and offset
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_ALLOCATED) |-> (rsp.granted_index == 2'd0 &&
     rsp.granted_offset == 6'd0))
    else $error("non-grant response with nonzero index or offset");

endmodule

bind fixed_block_free_list_allocator_top fbfl_checker #(
  .NUM_BLOCKS(NUM_BLOCKS)
) u_fbfl_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .req  (req),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import fbfl_pkg::*;

  localparam int NUM_BLOCKS  = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 230;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;

  // free list copy kept alongside the block
  logic [1:0] pool_head;
  logic       pool_drained;
  logic [1:0] pool_link [NUM_BLOCKS];
  logic       pool_link_end [NUM_BLOCKS];

  rsp_t grant_queue [$];
  int   sender_idle_pct;
  int   mismatch_count;
  int   stall_cycles;
  int   n_sent;
  int   n_granted;
  int   n_empty;
  int   n_freed;
  int   n_ignored;
  int   n_rebuilt;

  fixed_block_free_list_allocator_top #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // rebuild chain 0,1,2,... ending at the last block
  function automatic void rebuild_pool();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      pool_link[i]     = (i + 1 < NUM_BLOCKS) ? 2'(i + 1) : 2'd0;
      pool_link_end[i] = (i + 1 == NUM_BLOCKS);
    end
    pool_head    = '0;
    pool_drained = 1'b0;
  endfunction

  // apply one command to the free list copy and return the response it causes
  function automatic rsp_t apply_pool_command(req_t r);
    rsp_t       res;
    logic [1:0] h;
    res = '{status: ST_IGNORED, granted_index: '0, granted_offset: '0};
    case (r.command)
      CMD_ALLOC: begin
        if (pool_drained) begin
          res.status = ST_EMPTY;
        end else begin
          h                  = pool_head;
          res.status         = ST_ALLOCATED;
          res.granted_index  = h;
          res.granted_offset = 6'(int'(h) * BLOCK_BYTES);
          if (pool_link_end[h]) begin
            pool_drained = 1'b1;
          end else begin
            pool_head = pool_link[h];
          end
        end
      end
      CMD_FREE: begin
        if (r.block_present && int'(r.block_index) < NUM_BLOCKS) begin
          pool_link[r.block_index]     = pool_head;
          pool_link_end[r.block_index] = pool_drained;
          pool_head                    = r.block_index;
          pool_drained                 = 1'b0;
          res.status                   = ST_FREED;
        end
      end
      CMD_REINIT: begin
        rebuild_pool();
        res.status = ST_REINIT;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic req_t make_req(logic [1:0] cmd, logic [1:0] idx, logic present);
    req_t r;
    r.command       = cmd;
    r.block_index   = idx;
    r.block_present = present;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 30) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // send one command, with an optional random gap before it
  task automatic send_cmd(req_t r);
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      while ($urandom_range(99) < sender_idle_pct) begin
        @(negedge clk);
      end
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    grant_queue.push_back(apply_pool_command(r));
    n_sent++;
  endtask

  // hold off until every response has come back
  task automatic drain_pool();
    @(negedge clk);
    start <= 1'b0;
    while (grant_queue.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // reset chain hands out blocks in order, then reports empty
  task automatic test_allocate_all();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      send_cmd(make_req(CMD_ALLOC, 2'(i), i[0]));
    end
    send_cmd(make_req(CMD_ALLOC, 2'd3, 1'b1));
  endtask

  // frees: into an empty pool, null, unused command, lifo order, double free
  task automatic test_free_paths();
    send_cmd(make_req(CMD_FREE, 2'd2, 1'b1));
    send_cmd(make_req(CMD_ALLOC, 2'd0, 1'b0));
    send_cmd(make_req(CMD_ALLOC, 2'd0, 1'b0));
    send_cmd(make_req(CMD_FREE, 2'd3, 1'b0));
    send_cmd(make_req(CMD_UNUSED, 2'd3, 1'b1));
    send_cmd(make_req(CMD_FREE, 2'd3, 1'b1));
    send_cmd(make_req(CMD_FREE, 2'd1, 1'b1));
    send_cmd(make_req(CMD_ALLOC, 2'd2, 1'b1));
    send_cmd(make_req(CMD_ALLOC, 2'd1, 1'b0));
    send_cmd(make_req(CMD_FREE, 2'd1, 1'b1));
    send_cmd(make_req(CMD_FREE, 2'd1, 1'b1));
    send_cmd(make_req(CMD_ALLOC, 2'd0, 1'b0));
    send_cmd(make_req(CMD_ALLOC, 2'd0, 1'b0));
    send_cmd(make_req(CMD_ALLOC, 2'd0, 1'b0));
  endtask

  // rebuild restores the reset chain
  task automatic test_rebuild();
    send_cmd(make_req(CMD_REINIT, 2'd3, 1'b1));
    send_cmd(make_req(CMD_ALLOC, 2'd1, 1'b1));
    send_cmd(make_req(CMD_REINIT, 2'd0, 1'b0));
    send_cmd(make_req(CMD_ALLOC, 2'd2, 1'b0));
  endtask

  // mostly allocate and free so the list wraps and cycles, some noise
  task automatic test_random_traffic(int idle_pct, int count);
    int   pick;
    req_t r;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      r    = make_req(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      if (pick < 42) begin
        r.command = CMD_ALLOC;
      end else if (pick < 84) begin
        r.command       = CMD_FREE;
        r.block_present = 1'b1;
      end else if (pick < 90) begin
        r.command       = CMD_FREE;
        r.block_present = 1'b0;
      end else if (pick < 95) begin
        r.command = CMD_REINIT;
      end else begin
        r.command = CMD_UNUSED;
      end
      send_cmd(r);
    end
  endtask

  // response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (grant_queue.size() == 0) begin
          report_mismatch($sformatf("response with none pending, status %0d", rsp.status));
        end else begin
          want = grant_queue.pop_front();
          case (want.status)
            ST_ALLOCATED: n_granted++;
            ST_EMPTY:     n_empty++;
            ST_FREED:     n_freed++;
            ST_REINIT:    n_rebuilt++;
            default:      n_ignored++;
          endcase
          if (rsp.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
          end
          if (rsp.granted_index !== want.granted_index) begin
            report_mismatch($sformatf("granted_index %0d, want %0d",
                                      rsp.granted_index, want.granted_index));
          end
          if (rsp.granted_offset !== want.granted_offset) begin
            report_mismatch($sformatf("granted_offset %0d, want %0d",
                                      rsp.granted_offset, want.granted_offset));
          end
        end
      end else if (done !== 1'b0) begin
        report_mismatch("done is unknown");
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    req             = '0;
    sender_idle_pct = 0;
    mismatch_count  = 0;
    stall_cycles    = 0;
    n_sent          = 0;
    n_granted       = 0;
    n_empty         = 0;
    n_freed         = 0;
    n_ignored       = 0;
    n_rebuilt       = 0;
    rebuild_pool();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_allocate_all();
    test_free_paths();
    test_rebuild();
    drain_pool();
    test_random_traffic(12, RANDOM_ITEMS);
    drain_pool();
    test_random_traffic(66, RANDOM_ITEMS);
    test_random_traffic(0, RANDOM_ITEMS);

    // let the last responses arrive
    @(negedge clk);
    start <= 1'b0;
    while (grant_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (NUM_BLOCKS + 4) @(posedge clk);

    $display("sent %0d commands: %0d grants, %0d empty pools, %0d frees,", n_sent,
             n_granted, n_empty, n_freed);
    $display("%0d ignored frees or commands, %0d rebuilds, %0d mismatches", n_ignored,
             n_rebuilt, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> fixed_block_free_list_allocator_top.f
rtl/fbfl_pkg.sv
rtl/fbfl_ram.sv
rtl/fixed_block_free_list_allocator_top.sv
rtl/fbfl_checker.sv
tb/tb.sv
